@@ design/wia_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wia_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_SHL = 3'd3,
        OP_SHR = 3'd4
    } t_opcode;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_SEND = 5'b10000
    } t_state;

endpackage
`default_nettype wire

@@ design/wia_limb_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared limb datapath: add/sub with carry, or shifted-word assembly.
module wia_limb_unit
    import wia_pkg::*;
#(
    parameter int LIMB_BITS = 64
) (
    input  wire logic [2:0]           i_op,
    input  wire logic [LIMB_BITS-1:0] i_x,
    input  wire logic [LIMB_BITS-1:0] i_y,
    input  wire logic                 i_carry,
    output logic [LIMB_BITS-1:0]      o_z,
    output logic                      o_carry
);
    logic [LIMB_BITS:0] w_sum;

    always_comb begin
        w_sum   = '0;
        o_z     = '0;
        o_carry = 1'b0;
        unique case (i_op)
            OP_SUB: begin
                w_sum   = {1'b0, i_x} - {1'b0, i_y} - {{LIMB_BITS{1'b0}}, i_carry};
                o_z     = w_sum[LIMB_BITS-1:0];
                o_carry = w_sum[LIMB_BITS];
            end
            OP_SHL, OP_SHR: begin
                // x and y hold the two already-shifted source words
                o_z = i_x | i_y;
            end
            default: begin
                w_sum   = {1'b0, i_x} + {1'b0, i_y} + {{LIMB_BITS{1'b0}}, i_carry};
                o_z     = w_sum[LIMB_BITS-1:0];
                o_carry = w_sum[LIMB_BITS];
            end
        endcase
    end
endmodule
`default_nettype wire

@@ design/wide_integer_alu_512.sv @@
`timescale 1ns / 1ps
`default_nettype none
// 512-bit unsigned ALU (LIMB_COUNT limbs of LIMB_BITS). Each request loads one limb pair;
// with go the block first compares A and B from the top limb down, then runs one
// operation through a single limb-wide adder/shifter: add/sub/shift one limb at a time
// (spare opcodes give zero), and multiply by shift-add over every bit of B, one limb step
// per cycle. The result is then sent as LIMB_COUNT limbs, least significant first; no
// request is taken until the last limb leaves.
module wide_integer_alu_512
    import wia_pkg::*;
#(
    parameter int LIMB_COUNT = 8,
    parameter int LIMB_BITS  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_limb_index,
    input  wire logic [63:0] i_a_limb,
    input  wire logic [63:0] i_b_limb,
    input  wire logic        i_go,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [9:0]  i_shift_amount,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_result_limb,
    output logic [2:0]       o_result_index,
    output logic             o_last_limb,
    output logic             o_a_less_than_b,
    output logic             o_a_equals_b
);
    localparam int TOTAL = LIMB_COUNT * LIMB_BITS;
    localparam int IW    = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
    localparam int CW    = $clog2(LIMB_COUNT + 1);
    localparam int BW    = $clog2(TOTAL);
    localparam int RW    = (LIMB_BITS > 1) ? $clog2(LIMB_BITS) : 1;

    logic [LIMB_BITS-1:0] r_a [LIMB_COUNT];
    logic [LIMB_BITS-1:0] r_b [LIMB_COUNT];
    logic [LIMB_BITS-1:0] r_res [LIMB_COUNT];
    logic [LIMB_BITS-1:0] r_part [LIMB_COUNT];
    t_state               r_state;
    logic [2:0]           r_op;
    logic [9:0]           r_sh;
    logic [CW-1:0]        r_cnt;
    logic [BW-1:0]        r_bit;
    logic                 r_carry, r_lt, r_eq;

    logic                 w_acc;
    logic [IW-1:0]        w_k;
    logic [LIMB_BITS-1:0] w_x, w_y, w_z;
    logic                 w_cout;
    logic [2:0]           w_uop;
    logic [9:0]           w_q;
    logic [RW-1:0]        w_r;
    logic                 w_long;
    logic                 w_bbit;

    assign o_stall = (r_state != ST_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign w_k     = r_cnt[IW-1:0];
    assign w_q     = 10'(r_sh / LIMB_BITS);
    assign w_r     = RW'(r_sh % LIMB_BITS);
    assign w_long  = (r_sh >= 10'(TOTAL));
    assign w_bbit  = r_b[r_bit[BW-1:RW]][r_bit[RW-1:0]];

    // operand selection for the shared limb unit
    always_comb begin
        logic [10:0] s;
        logic [LIMB_BITS-1:0] lo, hi;
        s  = '0;
        lo = '0;
        hi = '0;
        w_x   = r_a[w_k];
        w_y   = r_b[w_k];
        w_uop = r_op;
        if (r_state == ST_MUL) begin
            w_x   = r_res[w_k];
            w_y   = w_bbit ? r_part[w_k] : '0;
            w_uop = OP_ADD;
        end else if (r_op == OP_SHL) begin
            s = 11'(w_k) - 11'(w_q);
            if (!s[10]) begin
                lo = r_a[s[IW-1:0]] << w_r;
                if (w_r != 0 && s != 0) hi = r_a[s[IW-1:0] - 1'b1] >> (RW'(LIMB_BITS) - w_r);
            end
            w_x = w_long ? '0 : lo;
            w_y = w_long ? '0 : hi;
        end else if (r_op == OP_SHR) begin
            s = 11'(w_k) + 11'(w_q);
            if (s < 11'(LIMB_COUNT)) begin
                lo = r_a[s[IW-1:0]] >> w_r;
                if (w_r != 0 && s + 11'd1 < 11'(LIMB_COUNT))
                    hi = r_a[s[IW-1:0] + 1'b1] << (RW'(LIMB_BITS) - w_r);
            end
            w_x = w_long ? '0 : lo;
            w_y = w_long ? '0 : hi;
        end
    end

    wia_limb_unit #(.LIMB_BITS(LIMB_BITS)) u_unit (
        .i_op(w_uop), .i_x(w_x), .i_y(w_y), .i_carry(r_carry),
        .o_z(w_z), .o_carry(w_cout)
    );

    // sequencer and storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_bit   <= '0;
            r_carry <= 1'b0;
            for (int i = 0; i < LIMB_COUNT; i++) begin
                r_a[i]   <= '0;
                r_b[i]   <= '0;
                r_res[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (32'(i_limb_index) < LIMB_COUNT) begin
                            r_a[i_limb_index[IW-1:0]] <= i_a_limb[LIMB_BITS-1:0];
                            r_b[i_limb_index[IW-1:0]] <= i_b_limb[LIMB_BITS-1:0];
                        end
                        r_op <= i_opcode;
                        r_sh <= i_shift_amount;
                        if (i_go) begin
                            r_state <= ST_CMP;
                            r_cnt   <= CW'(LIMB_COUNT - 1);
                            r_lt    <= 1'b0;
                            r_eq    <= 1'b1;
                        end
                    end
                end
                // compare from the top limb down
                ST_CMP: begin
                    if (r_eq && r_a[w_k] != r_b[w_k]) begin
                        r_eq <= 1'b0;
                        r_lt <= r_a[w_k] < r_b[w_k];
                    end
                    if (r_cnt == 0) begin
                        r_carry <= 1'b0;
                        if (r_op == OP_MUL) begin
                            r_state <= ST_MUL;
                            r_bit   <= '0;
                            for (int i = 0; i < LIMB_COUNT; i++) begin
                                r_res[i]  <= '0;
                                r_part[i] <= r_a[i];
                            end
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_RUN: begin
                    r_res[w_k] <= (r_op > OP_SHR) ? '0 : w_z;
                    r_carry    <= w_cout;
                    if (32'(r_cnt) == LIMB_COUNT - 1) begin
                        r_state <= ST_SEND;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                // one limb of acc += (b bit) ? part : 0 per cycle
                ST_MUL: begin
                    r_res[w_k] <= w_z;
                    if (32'(r_cnt) == LIMB_COUNT - 1) begin
                        r_cnt   <= '0;
                        r_carry <= 1'b0;
                        for (int i = 0; i < LIMB_COUNT; i++)
                            r_part[i] <= {r_part[i][LIMB_BITS-2:0],
                                          (i == 0) ? 1'b0 : r_part[(i+LIMB_COUNT-1)%LIMB_COUNT][LIMB_BITS-1]};
                        if (32'(r_bit) == TOTAL - 1) r_state <= ST_SEND;
                        else                         r_bit   <= r_bit + 1'b1;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_carry <= w_cout;
                    end
                end
                ST_SEND: begin
                    if (!i_stall) begin
                        if (32'(r_cnt) == LIMB_COUNT - 1) begin
                            r_state <= ST_IDLE;
                            r_cnt   <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result limbs
    assign o_valid         = (r_state == ST_SEND);
    assign o_result_limb   = 64'(r_res[w_k]);
    assign o_result_index  = 3'(r_cnt);
    assign o_last_limb     = (32'(r_cnt) == LIMB_COUNT - 1);
    assign o_a_less_than_b = r_lt;
    assign o_a_equals_b    = r_eq;

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accepting while sending");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_a_less_than_b && o_a_equals_b)) else $error("lt and eq both set");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_limb) |=> !o_valid) else $error("extra limb");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import wia_pkg::*;

    localparam int WIDE = 512;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [63:0] limb;
        logic [2:0]  index;
        logic        last;
        logic        lt;
        logic        eq;
    } t_limb_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_limb_index = '0;
    logic [63:0] i_a_limb = '0;
    logic [63:0] i_b_limb = '0;
    logic        i_go = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [9:0]  i_shift_amount = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_result_limb;
    logic [2:0]  o_result_index;
    logic        o_last_limb;
    logic        o_a_less_than_b;
    logic        o_a_equals_b;

    // shadow copy of the stored operands
    logic [WIDE-1:0] shadow_a = '0;
    logic [WIDE-1:0] shadow_b = '0;
    t_limb_result    pending_limbs[$];
    int              error_count = 0;
    int              cycle_count = 0;
    bit              stall_enable = 1'b1;

    wide_integer_alu_512 dut (.*);

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall: mostly short bursts, now and then a long one
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall = 1'b1;
        end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_limb_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_limbs.size() == 0) begin
                report_mismatch("unexpected result", o_result_limb, '0);
            end else begin
                want = pending_limbs.pop_front();
                if (o_result_limb !== want.limb)
                    report_mismatch("limb", o_result_limb, want.limb);
                if (o_result_index !== want.index)
                    report_mismatch("index", 64'(o_result_index), 64'(want.index));
                if (o_last_limb !== want.last)
                    report_mismatch("last", 64'(o_last_limb), 64'(want.last));
                if (o_a_less_than_b !== want.lt)
                    report_mismatch("less", 64'(o_a_less_than_b), 64'(want.lt));
                if (o_a_equals_b !== want.eq)
                    report_mismatch("equal", 64'(o_a_equals_b), 64'(want.eq));
            end
        end
    end

    // expected 512-bit result of one operation on the shadow operands
    function automatic logic [WIDE-1:0] alu_result(input logic [2:0] op,
                                                  input logic [9:0] amount);
        case (op)
            OP_ADD: return shadow_a + shadow_b;
            OP_SUB: return shadow_a - shadow_b;
            OP_MUL: return shadow_a * shadow_b;
            OP_SHL: return (amount >= WIDE) ? '0 : shadow_a << amount;
            OP_SHR: return (amount >= WIDE) ? '0 : shadow_a >> amount;
            default: return '0;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] idx, input logic [63:0] a,
                                input logic [63:0] b, input logic go,
                                input logic [2:0] op, input logic [9:0] amount,
                                input bit gaps);
        logic [WIDE-1:0] res;
        int gap;
        i_limb_index = idx;
        i_a_limb = a;
        i_b_limb = b;
        i_go = go;
        i_opcode = op;
        i_shift_amount = amount;
        i_valid = 1'b1;
        // stall only moves at the rising edge, so it is steady at the falling one
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        // request taken: update the shadow and queue the expected limbs
        shadow_a[idx*64 +: 64] = a;
        shadow_b[idx*64 +: 64] = b;
        if (go) begin
            res = alu_result(op, amount);
            for (int k = 0; k < 8; k++)
                pending_limbs.push_back('{res[k*64 +: 64], 3'(k), k == 7,
                                         shadow_a < shadow_b, shadow_a == shadow_b});
        end
        @(negedge i_clk);
        if (gaps && $urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                               : $urandom_range(1, 3);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b0;
    endtask

    task automatic load_and_run(input logic [WIDE-1:0] a, input logic [WIDE-1:0] b,
                                input logic [2:0] op, input logic [9:0] amount);
        for (int k = 0; k < 8; k++)
            send_request(3'(k), a[k*64 +: 64], b[k*64 +: 64], k == 7, op, amount, 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_limbs.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_limb();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // extremes: wrap on add/sub, full multiply
    task automatic test_arith_extremes();
        load_and_run('1, {{WIDE-1{1'b0}}, 1'b1}, OP_ADD, '0);
        load_and_run('0, {{WIDE-1{1'b0}}, 1'b1}, OP_SUB, '0);
        load_and_run('1, '1, OP_MUL, '0);
        send_request(3'd0, '1, '1, 1'b1, OP_ADD, '0, 1'b0);
    endtask

    // shifts at zero, 65, 511, exactly 512 and beyond
    task automatic test_shifts();
        send_request(3'd3, '1, '0, 1'b1, OP_SHL, 10'd0, 1'b0);
        send_request(3'd7, '1, '0, 1'b1, OP_SHL, 10'd511, 1'b0);
        send_request(3'd7, '1, '0, 1'b1, OP_SHL, 10'd512, 1'b0);
        send_request(3'd5, 64'h8000_0000_0000_0001, '1, 1'b1, OP_SHR, 10'd65, 1'b0);
        send_request(3'd5, '1, '1, 1'b1, OP_SHR, 10'd1023, 1'b0);
    endtask

    // spare opcodes give zero, plain loads give nothing
    task automatic test_spare_and_loads();
        send_request(3'd2, '0, '1, 1'b0, OP_ADD, '0, 1'b0);
        send_request(3'd2, '0, '1, 1'b1, OP_SPARE_LO, '0, 1'b0);
        send_request(3'd4, '1, '0, 1'b1, OP_SPARE_HI, '1, 1'b0);
    endtask

    task automatic test_random(input int count);
        logic [2:0] op;
        logic [9:0] amount;
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 5) == 0) begin
                // full operand load then one operation
                op = ($urandom_range(0, 9) == 0) ? OP_MUL : 3'($urandom_range(0, 7));
                if (op == OP_MUL && $urandom_range(0, 1) == 0) op = OP_ADD;
                amount = 10'($urandom_range(0, 1023));
                for (int k = 0; k < 8; k++)
                    send_request(3'(k), pick_limb(), pick_limb(), k == 7, op, amount, 1'b1);
                sent += 8;
            end else begin
                op = 3'($urandom_range(0, 7));
                if (op == OP_MUL) op = OP_SUB;
                amount = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(500, 520))
                                                     : 10'($urandom_range(0, 1023));
                send_request(3'($urandom_range(0, 7)), pick_limb(), pick_limb(),
                             $urandom_range(0, 3) == 0, op, amount, 1'b1);
                sent++;
            end
            if (sent > count / 2 && sent < count / 2 + 10) wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_arith_extremes();
        test_shifts();
        test_spare_and_loads();
        wait_drained();
        test_random(350);
        wait_drained();
        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
